// File: hw/rtl/spp_pkg.sv
package spp_pkg;

	localparam int CW   = 32;          // coordinate width
	localparam int DW   = CW + 1;      // centre delta width
	localparam int SW   = 2 * DW;      // sum of squares width
	localparam int RW   = SW / 2;      // root width
	localparam int RADW = CW - 1;      // radius width
	localparam int PW   = RADW + DW;   // radius times delta magnitude
	localparam int QW   = RADW;        // offset quotient width
	localparam int GW   = RW + 2;      // gap and point sum width
	localparam int IDXW = 2;

	localparam logic [IDXW-1:0] REG_RADIUS_ONE = 2'd0;
	localparam logic [IDXW-1:0] REG_RADIUS_TWO = 2'd1;

	typedef struct packed {
		logic          first_is_sphere_one;
		logic [CW-1:0] first_center_x;
		logic [CW-1:0] first_center_y;
		logic [CW-1:0] first_center_z;
		logic [CW-1:0] second_center_x;
		logic [CW-1:0] second_center_y;
		logic [CW-1:0] second_center_z;
	} query_t;

	typedef struct packed {
		logic [CW-1:0] gap_distance;
		logic [CW-1:0] near_first_x;
		logic [CW-1:0] near_first_y;
		logic [CW-1:0] near_first_z;
		logic [CW-1:0] near_second_x;
		logic [CW-1:0] near_second_y;
		logic [CW-1:0] near_second_z;
		logic          degenerate;
	} result_t;

	// Per-item context carried down the pipeline
	typedef struct packed {
		logic [2:0][CW-1:0] c1;
		logic [2:0][CW-1:0] c2;
		logic [2:0][DW-1:0] dl;
		logic [RADW-1:0]    r1;
		logic [RADW-1:0]    r2;
	} ctx_t;

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
		mag = v[DW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [CW-1:0] sat(input logic [GW-1:0] v);
		logic [GW-1:0] hi;
		logic [GW-1:0] lo;
		hi = GW'((64'd1 << (CW - 1)) - 64'd1);
		lo = ~hi;
		if (!v[GW-1] && (v > hi))
			sat = hi[CW-1:0];
		else if (v[GW-1] && (v < lo))
			sat = lo[CW-1:0];
		else
			sat = v[CW-1:0];
	endfunction

endpackage

// File: hw/rtl/sphere_pair_proximity.sv
// Sphere pair proximity: one query beat per clock, no stalls. A beat is taken when start is
// high (busy stays low), and its result appears on result with result_valid high for exactly
// one cycle. The latency is set by the bit-per-stage square root (one stage per root bit)
// followed by the bit-per-stage dividers (one stage per offset bit); every stage is
// registered, so throughput is one beat per cycle. The receiver must take every result when
// it is shown. Radii are written over the cfg port (always ready) and may only change while
// no query is in flight. Coincident centres set degenerate; the near points then equal the
// centres and the gap is minus both radii.
module sphere_pair_proximity (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  spp_pkg::query_t             query,
	output logic                        result_valid,
	output spp_pkg::result_t            result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [spp_pkg::IDXW-1:0]    cfg_index,
	input  logic [spp_pkg::CW-1:0]      cfg_data
);

	localparam int CW   = spp_pkg::CW;
	localparam int DW   = spp_pkg::DW;
	localparam int SW   = spp_pkg::SW;
	localparam int RW   = spp_pkg::RW;
	localparam int RADW = spp_pkg::RADW;
	localparam int PW   = spp_pkg::PW;
	localparam int QW   = spp_pkg::QW;
	localparam int GW   = spp_pkg::GW;

	// Never stall: pipeline advances every cycle
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	logic accept;
	assign accept = start && !busy;

	// Radius registers
	logic [RADW-1:0] radius_one_q;
	logic [RADW-1:0] radius_two_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_one_q <= '0;
			radius_two_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spp_pkg::REG_RADIUS_ONE: radius_one_q <= cfg_data[RADW-1:0];
				spp_pkg::REG_RADIUS_TWO: radius_two_q <= cfg_data[RADW-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: deltas and radius routing
	logic         v_s1;
	spp_pkg::ctx_t ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		ctx_s1.c1[0] <= query.first_center_x;
		ctx_s1.c1[1] <= query.first_center_y;
		ctx_s1.c1[2] <= query.first_center_z;
		ctx_s1.c2[0] <= query.second_center_x;
		ctx_s1.c2[1] <= query.second_center_y;
		ctx_s1.c2[2] <= query.second_center_z;
		ctx_s1.dl[0] <= {query.second_center_x[CW-1], query.second_center_x}
			- {query.first_center_x[CW-1], query.first_center_x};
		ctx_s1.dl[1] <= {query.second_center_y[CW-1], query.second_center_y}
			- {query.first_center_y[CW-1], query.first_center_y};
		ctx_s1.dl[2] <= {query.second_center_z[CW-1], query.second_center_z}
			- {query.first_center_z[CW-1], query.first_center_z};
		ctx_s1.r1 <= query.first_is_sphere_one ? radius_one_q : radius_two_q;
		ctx_s1.r2 <= query.first_is_sphere_one ? radius_two_q : radius_one_q;
	end

	// Stage 2: squares
	logic                v_s2;
	spp_pkg::ctx_t       ctx_s2;
	logic [2:0][SW-1:0]  sq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_s1;
		for (int i = 0; i < 3; i++)
			sq_s2[i] <= SW'(spp_pkg::mag(ctx_s1.dl[i])) * SW'(spp_pkg::mag(ctx_s1.dl[i]));
	end

	// Square root: index 0 holds the summed radicand, each later index resolves one root bit
	logic                sqrt_v   [0:RW];
	spp_pkg::ctx_t       sqrt_ctx [0:RW];
	logic [SW-1:0]       sqrt_rad [0:RW];
	logic [RW-1:0]       sqrt_root[0:RW];
	logic [RW+1:0]       sqrt_rem [0:RW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sqrt_v[0] <= 1'b0;
		else
			sqrt_v[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		sqrt_ctx[0]  <= ctx_s2;
		sqrt_rad[0]  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		sqrt_root[0] <= '0;
		sqrt_rem[0]  <= '0;
	end

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RW+1:0] rem_sh;
		logic [RW+1:0] trial;
		logic          ge;

		always_comb begin
			rem_sh = {sqrt_rem[k][RW-1:0], sqrt_rad[k][SW-1:SW-2]};
			trial  = {sqrt_root[k], 2'b01};
			ge     = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sqrt_v[k+1] <= 1'b0;
			else
				sqrt_v[k+1] <= sqrt_v[k];
		end

		always_ff @(posedge clk) begin
			sqrt_ctx[k+1]  <= sqrt_ctx[k];
			sqrt_rad[k+1]  <= {sqrt_rad[k][SW-3:0], 2'b00};
			sqrt_root[k+1] <= {sqrt_root[k][RW-2:0], ge};
			sqrt_rem[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
		end
	end

	// Products, gap, degenerate flag; divider index 0
	logic [RW-1:0] root_dist;
	assign root_dist = sqrt_root[RW];

	logic                   div_v    [0:QW];
	spp_pkg::ctx_t          div_ctx  [0:QW];
	logic [RW-1:0]          div_dist [0:QW];
	logic [CW-1:0]          div_gap  [0:QW];
	logic                   div_deg  [0:QW];
	logic [5:0][RW-1:0]     div_rem  [0:QW];
	logic [5:0][QW-1:0]     div_low  [0:QW];
	logic [5:0][QW-1:0]     div_quo  [0:QW];

	logic [5:0][PW-1:0] prod;
	logic [GW-1:0]      gap_full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i]     = PW'(sqrt_ctx[RW].r1) * PW'(spp_pkg::mag(sqrt_ctx[RW].dl[i]));
			prod[i + 3] = PW'(sqrt_ctx[RW].r2) * PW'(spp_pkg::mag(sqrt_ctx[RW].dl[i]));
		end
		gap_full = GW'(root_dist) - GW'(sqrt_ctx[RW].r1) - GW'(sqrt_ctx[RW].r2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			div_v[0] <= 1'b0;
		else
			div_v[0] <= sqrt_v[RW];
	end

	always_ff @(posedge clk) begin
		div_ctx[0]  <= sqrt_ctx[RW];
		div_dist[0] <= root_dist;
		div_gap[0]  <= spp_pkg::sat(gap_full);
		div_deg[0]  <= root_dist == '0;
		for (int i = 0; i < 6; i++) begin
			// Quotient is below 2^QW, so the top bits already sit below the divisor
			div_rem[0][i] <= prod[i][PW-1:QW];
			div_low[0][i] <= prod[i][QW-1:0];
			div_quo[0][i] <= '0;
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [5:0][RW:0] sh;
		logic [5:0]       ge;

		always_comb begin
			for (int i = 0; i < 6; i++) begin
				sh[i] = {div_rem[j][i], div_low[j][i][QW-1]};
				ge[i] = sh[i] >= {1'b0, div_dist[j]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				div_v[j+1] <= 1'b0;
			else
				div_v[j+1] <= div_v[j];
		end

		always_ff @(posedge clk) begin
			div_ctx[j+1]  <= div_ctx[j];
			div_dist[j+1] <= div_dist[j];
			div_gap[j+1]  <= div_gap[j];
			div_deg[j+1]  <= div_deg[j];
			for (int i = 0; i < 6; i++) begin
				div_rem[j+1][i] <= ge[i] ? RW'(sh[i] - {1'b0, div_dist[j]}) : sh[i][RW-1:0];
				div_low[j+1][i] <= {div_low[j][i][QW-2:0], 1'b0};
				div_quo[j+1][i] <= {div_quo[j][i][QW-2:0], ge[i]};
			end
		end
	end

	// Final stage: apply signs, add offsets to first centres and subtract from second, clamp
	spp_pkg::ctx_t     fctx;
	logic [2:0][GW-1:0] p1;
	logic [2:0][GW-1:0] p2;

	always_comb begin
		fctx = div_ctx[QW];
		for (int i = 0; i < 3; i++) begin
			logic [GW-1:0] o1;
			logic [GW-1:0] o2;
			o1 = div_deg[QW] ? '0 : GW'(div_quo[QW][i]);
			o2 = div_deg[QW] ? '0 : GW'(div_quo[QW][i + 3]);
			if (fctx.dl[i][DW-1]) begin
				o1 = ~o1 + 1'b1;
				o2 = ~o2 + 1'b1;
			end
			p1[i] = {{(GW-CW){fctx.c1[i][CW-1]}}, fctx.c1[i]} + o1;
			p2[i] = {{(GW-CW){fctx.c2[i][CW-1]}}, fctx.c2[i]} - o2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid <= 1'b0;
		else
			result_valid <= div_v[QW];
	end

	always_ff @(posedge clk) begin
		result.gap_distance  <= div_gap[QW];
		result.near_first_x  <= spp_pkg::sat(p1[0]);
		result.near_first_y  <= spp_pkg::sat(p1[1]);
		result.near_first_z  <= spp_pkg::sat(p1[2]);
		result.near_second_x <= spp_pkg::sat(p2[0]);
		result.near_second_y <= spp_pkg::sat(p2[1]);
		result.near_second_z <= spp_pkg::sat(p2[2]);
		result.degenerate    <= div_deg[QW];
	end

	// Square root remainder stays within twice the root
	a_sqrt_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_v[RW] |-> (sqrt_rem[RW] <= {1'b0, sqrt_root[RW], 1'b0}))
		else $error("sqrt remainder out of bound");

	// Dividers 0 and 3 end with a remainder below the distance on non-degenerate results
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(div_v[QW] && !div_deg[QW]) |-> (div_rem[QW][0] < div_dist[QW])
			&& (div_rem[QW][3] < div_dist[QW]))
		else $error("divider remainder not below distance");

	// Coincident centres never give a positive gap
	a_deg_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.degenerate) |-> !(result.gap_distance != '0
			&& !result.gap_distance[CW-1]))
		else $error("positive gap on degenerate result");

endmodule
